/* design/assert_macros.svh */
// Assertion macros used by the matrix unit RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising edge, masked while in reset.
`define SMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define SMA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sma_pkg.sv */
// Package for the square matrix add / subtract / multiply unit.
// Constants, register indexes, reset values and sequencer state type. No dependencies.
package sma_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;
	localparam int VALUE_W        = 40;
	localparam int RC_W           = 3;
	localparam int MODE_W         = 2;
	localparam int SIZE_W         = 4;
	localparam int CFG_DATA_W     = 4;
	localparam int FRAC_SHIFT     = 8;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_FLUSH,
		ST_DRAIN
	} seq_state_t;

endpackage

/* design/sma_store.sv */
// Element store: one write port, one registered read port.
// Uses sma_pkg only for its house constants.
module sma_store #(
	parameter int DEPTH  = sma_pkg::MAX_DIM_DEF * sma_pkg::MAX_DIM_DEF,
	parameter int WIDTH  = sma_pkg::ELEM_WIDTH_DEF,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);
	import sma_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/sma_term.sv */
// Term unit: registered product or shifted sum / difference of two elements.
// Depends on sma_pkg.
module sma_term #(
	parameter int ELEM_WIDTH = sma_pkg::ELEM_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [sma_pkg::MODE_W-1:0] mode,
	input  logic [ELEM_WIDTH-1:0]      a,
	input  logic [ELEM_WIDTH-1:0]      b,
	output logic                       term_valid,
	output logic [sma_pkg::VALUE_W-1:0] term
);
	import sma_pkg::*;

	localparam int WW = 2 * ELEM_WIDTH + FRAC_SHIFT + 1;

	logic signed [2*ELEM_WIDTH-1:0] prod;
	logic signed [ELEM_WIDTH:0]     sum;
	logic signed [WW-1:0]           wide;
	logic                           term_v_s2;
	logic [VALUE_W-1:0]             term_s2;

	always_comb begin
		prod = $signed(a) * $signed(b);
		if (mode[0]) begin
			sum = $signed({a[ELEM_WIDTH-1], a}) - $signed({b[ELEM_WIDTH-1], b});
		end else begin
			sum = $signed({a[ELEM_WIDTH-1], a}) + $signed({b[ELEM_WIDTH-1], b});
		end
		if (mode[1]) begin
			wide = {{(WW-2*ELEM_WIDTH){prod[2*ELEM_WIDTH-1]}}, prod};
		end else begin
			wide = {{(WW-ELEM_WIDTH-1){sum[ELEM_WIDTH]}}, sum} <<< FRAC_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_v_s2 <= 1'b0;
		end else begin
			term_v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			term_s2 <= wide[VALUE_W-1:0];
		end
	end

	assign term_valid = term_v_s2;
	assign term       = term_s2;

endmodule

/* design/sma_cell.sv */
// Accumulator cell of the rotating result chain.
// Depends on sma_pkg.
module sma_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic                        shift_en,
	input  logic [sma_pkg::VALUE_W-1:0] d,
	output logic [sma_pkg::VALUE_W-1:0] q
);
	import sma_pkg::*;

	logic [VALUE_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (shift_en) begin
			acc_q <= d;
		end
	end

	assign q = acc_q;

endmodule

/* design/square_matrix_add_sub_mul_core.sv */
// Square matrix add / subtract / multiply core, top level.
// Uses sma_pkg, sma_store, sma_term, sma_cell and assert_macros.svh.
//
// Usage:
//  s_axis carries one pair of Q8.8 elements per transfer (A low, B high), row-major.
//  When n*n pairs are in (n from the size register, 0 taken as 1, clamped to MAX_DIM),
//  the core computes A+B, A-B or A*B (mode 0, 1, 2/3) and sends n*n Q24.16 results
//  on m_axis in row-major order, with row and column in tdata and tlast on the last.
//  Loading: one pair per cycle; s_axis_tready is low while a result matrix is made.
//  Product: one multiply-accumulate per cycle while issuing. Each result row feeds n*n
//  terms into a rotating chain of n accumulator cells, then flushes the pipeline,
//  then shifts the row out of the chain; the next row is not issued before that.
//  Sum and difference: n terms per row, then pipeline flush and row shift-out.
//  For a product, the first result follows the completing transfer once the first
//  row's terms are accumulated and the pipeline is flushed.
//  A stalled m_axis holds the result register and the chain; nothing is lost.
//  Reset clears the sequencer, load count and chain, and sets mode 0, size 8.
//  Registers are to be written with cfg_wr_en only while the core is idle; the core does not enforce this.
module square_matrix_add_sub_mul_core #(
	parameter int MAX_DIM    = sma_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = sma_pkg::ELEM_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [sma_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: a_elem, b_elem, zero fill
	input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata: value[39:0], row[42:40], col[45:43], zero fill
	output logic [47:0]                    m_axis_tdata,
	output logic                           m_axis_tlast
);
	import sma_pkg::*;

	`include "assert_macros.svh"

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int NW    = $clog2(MAX_DIM + 1);
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [MODE_W-1:0] mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [NW-1:0]     n;
	logic [NW-1:0]     n_m1;
	logic [CW-1:0]     total;
	logic              mul;

	seq_state_t state_q, state_d;

	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] load_next;
	logic          in_xfer;
	logic          load_done;

	logic [NW-1:0] i_q, j_q, k_q, dj_q;
	logic [AW-1:0] a_base_q, b_row_q;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic          issue;
	logic          issue_last;
	logic          rd_v_s1;
	logic          pipe_empty;
	logic          drain_step;
	logic          drain_last;
	logic          row_last;

	logic [ELEM_WIDTH-1:0] a_rd, b_rd;
	logic                  term_v;
	logic [VALUE_W-1:0]    term;

	logic [VALUE_W-1:0] cell_q [MAX_DIM];
	logic [VALUE_W-1:0] head_d;
	logic [VALUE_W-1:0] tail;
	logic               chain_shift;
	logic               chain_clr;

	logic               out_v_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [RC_W-1:0]    out_row_q, out_col_q;
	logic               out_last_q;
	logic [NW+RC_W-1:0] row_ext, col_ext;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			size_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_q == '0) begin
			n = NW'(1);
		end else if (32'(size_q) > MAX_DIM) begin
			n = NW'(MAX_DIM);
		end else begin
			n = NW'(size_q);
		end
		n_m1  = n - NW'(1);
		total = CW'(n * n);
		mul   = mode_q[1];
	end

	// load
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign load_next     = load_cnt_q + CW'(1);
	assign load_done     = in_xfer && (load_next >= total);

	// issue of element reads
	assign issue      = (state_q == ST_ISSUE);
	assign issue_last = (j_q == n_m1) && (!mul || (k_q == n_m1));
	assign rd_addr_a  = a_base_q + AW'(mul ? k_q : j_q);
	assign rd_addr_b  = (mul ? b_row_q : a_base_q) + AW'(j_q);
	assign pipe_empty = !rd_v_s1 && !term_v;

	// drain
	assign drain_step = (state_q == ST_DRAIN) && (!out_v_q || m_axis_tready);
	assign drain_last = (dj_q == n_m1);
	assign row_last   = (i_q == n_m1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (load_done) state_d = ST_ISSUE;
			ST_ISSUE: if (issue_last) state_d = ST_FLUSH;
			ST_FLUSH: if (pipe_empty) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (drain_step && drain_last) begin
					state_d = row_last ? ST_LOAD : ST_ISSUE;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		chain_clr   = (state_q == ST_LOAD) && load_done;
		chain_shift = term_v || drain_step;
		head_d      = drain_step ? '0 : (tail + term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			dj_q       <= '0;
			a_base_q   <= '0;
			b_row_q    <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (in_xfer) begin
				load_cnt_q <= load_done ? '0 : load_next;
			end
			if (issue) begin
				if (j_q == n_m1) begin
					j_q <= '0;
					if (mul && (k_q != n_m1)) begin
						k_q     <= k_q + NW'(1);
						b_row_q <= b_row_q + AW'(n);
					end else begin
						k_q     <= '0;
						b_row_q <= '0;
					end
				end else begin
					j_q <= j_q + NW'(1);
				end
			end
			if (drain_step) begin
				if (drain_last) begin
					dj_q <= '0;
					if (row_last) begin
						i_q      <= '0;
						a_base_q <= '0;
					end else begin
						i_q      <= i_q + NW'(1);
						a_base_q <= a_base_q + AW'(n);
					end
				end else begin
					dj_q <= dj_q + NW'(1);
				end
			end
		end
	end

	sma_store #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .ADDR_W(AW)) u_store_a (
		.clk     (clk),
		.wr_en   (in_xfer),
		.wr_addr (load_cnt_q[AW-1:0]),
		.wr_data (s_axis_tdata[ELEM_WIDTH-1:0]),
		.rd_en   (issue),
		.rd_addr (rd_addr_a),
		.rd_data (a_rd)
	);

	sma_store #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .ADDR_W(AW)) u_store_b (
		.clk     (clk),
		.wr_en   (in_xfer),
		.wr_addr (load_cnt_q[AW-1:0]),
		.wr_data (s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
		.rd_en   (issue),
		.rd_addr (rd_addr_b),
		.rd_data (b_rd)
	);

	sma_term #(.ELEM_WIDTH(ELEM_WIDTH)) u_term (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rd_v_s1),
		.mode       (mode_q),
		.a          (a_rd),
		.b          (b_rd),
		.term_valid (term_v),
		.term       (term)
	);

	// rotating accumulator chain, length n
	assign tail = cell_q[n_m1[IW-1:0]];

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		if (c == 0) begin : g_head
			sma_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (chain_clr),
				.shift_en (chain_shift),
				.d        (head_d),
				.q        (cell_q[c])
			);
		end else begin : g_body
			sma_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (chain_clr),
				.shift_en (chain_shift),
				.d        (cell_q[c-1]),
				.q        (cell_q[c])
			);
		end
	end

	// output register
	assign row_ext = {{RC_W{1'b0}}, i_q};
	assign col_ext = {{RC_W{1'b0}}, dj_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (drain_step) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			out_value_q <= tail;
			out_row_q   <= row_ext[RC_W-1:0];
			out_col_q   <= col_ext[RC_W-1:0];
			out_last_q  <= drain_last && row_last;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_col_q, out_row_q, out_value_q};
	assign m_axis_tlast  = out_last_q;

	`SMA_ASSERT(a_term_in_compute, term_v |-> (state_q == ST_ISSUE || state_q == ST_FLUSH), "term outside compute")
	`SMA_ASSERT(a_drain_fills_out, drain_step |=> m_axis_tvalid, "drained element not presented")
	`SMA_ASSERT(a_load_count_step, in_xfer |=> (load_cnt_q == '0 || load_cnt_q == $past(load_cnt_q) + CW'(1)), "load count jumped")
	`SMA_ASSERT_ALWAYS(a_pipe_idle_load, (state_q == ST_LOAD) |-> !rd_v_s1, "read issued while loading")

endmodule

/* test/tb.sv */
// Testbench for square_matrix_add_sub_mul_core: loads random and corner-case matrices,
// predicts sum, difference and product results, and checks every output transfer.
// Depends on sma_pkg and the core RTL only.
`timescale 1ns / 100ps

class matrix_scoreboard;
	logic [15:0] a_mem [64];
	logic [15:0] b_mem [64];
	int unsigned pair_count;
	logic [1:0] op_mode;
	logic [3:0] dim_reg;
	logic [39:0] exp_value [$];
	logic [2:0] exp_row [$];
	logic [2:0] exp_col [$];
	logic exp_last [$];
	int errors;
	int results_seen;
	int matrices;

	function void reset_state();
		pair_count = 0;
		op_mode = sma_pkg::MODE_RESET;
		dim_reg = sma_pkg::SIZE_RESET;
	endfunction

	function void write_reg(logic idx, logic [3:0] data);
		if (idx == sma_pkg::REG_MODE)
			op_mode = data[1:0];
		else
			dim_reg = data;
	endfunction

	function int unsigned dim();
		int unsigned n;
		n = dim_reg;
		if (n == 0) n = 1;
		if (n > 8) n = 8;
		return n;
	endfunction

	function void note_pair(logic [15:0] a, logic [15:0] b);
		int unsigned n, i, j, k, total;
		logic signed [63:0] acc;
		n = dim();
		total = n * n;
		if (pair_count < 64) begin
			a_mem[pair_count] = a;
			b_mem[pair_count] = b;
		end
		pair_count++;
		if (pair_count < total) return;
		pair_count = 0;
		matrices++;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				acc = 0;
				if (op_mode[1]) begin
					for (k = 0; k < n; k++)
						acc += $signed(a_mem[i*n+k]) * $signed(b_mem[k*n+j]);
				end else if (op_mode[0]) begin
					acc = ($signed(a_mem[i*n+j]) - $signed(b_mem[i*n+j])) <<< 8;
				end else begin
					acc = ($signed(a_mem[i*n+j]) + $signed(b_mem[i*n+j])) <<< 8;
				end
				exp_value.push_back(acc[39:0]);
				exp_row.push_back(i[2:0]);
				exp_col.push_back(j[2:0]);
				exp_last.push_back(i*n+j+1 == total);
			end
		end
	endfunction

	function void check_result(logic [47:0] data, logic lst);
		logic [39:0] v;
		logic [2:0] r, c;
		logic l;
		results_seen++;
		if (exp_value.size() == 0) begin
			$error("unexpected result transfer %h", data);
			errors++;
			return;
		end
		v = exp_value.pop_front();
		r = exp_row.pop_front();
		c = exp_col.pop_front();
		l = exp_last.pop_front();
		if (data[39:0] !== v) begin
			$error("value: expected %h, got %h", v, data[39:0]);
			errors++;
		end
		if (data[42:40] !== r) begin
			$error("row: expected %0d, got %0d", r, data[42:40]);
			errors++;
		end
		if (data[45:43] !== c) begin
			$error("col: expected %0d, got %0d", c, data[45:43]);
			errors++;
		end
		if (lst !== l) begin
			$error("last: expected %b, got %b", l, lst);
			errors++;
		end
	endfunction

	function int pending();
		return exp_value.size();
	endfunction
endclass

module tb;
	import sma_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;

	matrix_scoreboard sb;
	int idle_cycles;
	bit hold_off;
	int items_sent;

	square_matrix_add_sub_mul_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// watchdog and sampling at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (s_axis_tvalid && s_axis_tready)
				sb.note_pair(s_axis_tdata[15:0], s_axis_tdata[31:16]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tlast);
			if (idle_cycles > WATCHDOG) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0 && $urandom_range(0, 3) != 0) begin
				m_axis_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_pair(logic [15:0] a, logic [15:0] b, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tdata <= {b, a};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		end_burst();
		while (sb.pending() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [3:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function automatic logic [15:0] rand_elem();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 16'h8000;
		if (p == 1) return 16'h7fff;
		if (p == 2) return 16'hffff;
		if (p == 3) return 16'h0000;
		return 16'($urandom());
	endfunction

	task automatic send_matrix(int unsigned cnt, bit gaps);
		repeat (cnt) send_pair(rand_elem(), rand_elem(), gaps);
	endtask

	initial begin
		int unsigned n, md;
		sb = new();
		sb.reset_state();
		sb.errors = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes at n=1 and n=2, every mode, size 0 and above max
		write_cfg(REG_SIZE, 4'd1);
		for (int m = 0; m < 4; m++) begin
			write_cfg(REG_MODE, m[3:0]);
			send_pair(16'h8000, 16'h8000, 0);
			send_pair(16'h7fff, 16'h8000, 0);
			wait_idle();
		end
		write_cfg(REG_SIZE, 4'd0);
		write_cfg(REG_MODE, 4'd2);
		send_pair(16'h8000, 16'h7fff, 0);
		wait_idle();
		write_cfg(REG_SIZE, 4'd2);
		send_pair(16'h8000, 16'h8000, 0);
		send_pair(16'h8000, 16'h8000, 0);
		send_pair(16'h8000, 16'h8000, 0);
		send_pair(16'h8000, 16'h8000, 0);
		wait_idle();
		write_cfg(REG_SIZE, 4'd15);
		write_cfg(REG_MODE, 4'd1);
		send_matrix(64, 0);
		wait_idle();

		// size changed mid-load: shrink after 5 pairs at n=3 to n=2 completes at once
		write_cfg(REG_MODE, 4'd0);
		write_cfg(REG_SIZE, 4'd3);
		send_matrix(5, 0);
		wait_idle();
		write_cfg(REG_SIZE, 4'd2);
		send_pair(16'h1234, 16'hfedc, 0);
		wait_idle();

		// long receiver hold-off while three product matrices are loaded
		write_cfg(REG_SIZE, 4'd2);
		write_cfg(REG_MODE, 4'd2);
		hold_off = 1'b1;
		send_matrix(12, 0);
		wait_idle();

		// random phases, mostly small sizes
		while (items_sent < 400) begin
			md = $urandom_range(0, 3);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 4);
			write_cfg(REG_MODE, md[3:0]);
			write_cfg(REG_SIZE, n[3:0]);
			send_matrix(n * n * $urandom_range(1, 3), 1);
			wait_idle();
		end

		$display("Covered %0d input transfers, %0d matrices, %0d result transfers.",
			items_sent, sb.matrices, sb.results_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
